### hw/rtl/lsc_pkg.sv
// Package for the LRU slot cache: field widths, operation and result codes,
// slot entry type and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lsc_pkg;

    localparam int FUNC_W  = 3;
    localparam int ID_W    = 32;
    localparam int FRAME_W = 48;
    localparam int FNS_W   = 32;
    localparam int SEL_W   = 6;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int HOVER_W = 64;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STALE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RENDER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    item;
        logic [FRAME_W-1:0] last_use;
        logic [HOVER_W-1:0] hover;
    } lsc_entry_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic mark_stale;
        logic flush;
        logic commit_lookup;
        logic emit_ack;
        logic drain_start;
        logic drain_read;
        logic drain_skip;
        logic emit_render;
    } lsc_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              found;
        logic              scan_done;
        logic              out_free;
        logic              drain_hit;
        logic              drain_end;
        logic              emitted;
    } lsc_sts_t;

endpackage

`default_nettype wire

### hw/rtl/lsc_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on lsc_pkg.
`default_nettype none

interface lsc_req_if import lsc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    item_id;
    logic [FRAME_W-1:0] frame_index;
    logic               hovered;
    logic [FNS_W-1:0]   frame_ns;
    logic [SEL_W-1:0]   slot_sel;

    modport source (output valid, func, item_id, frame_index, hovered, frame_ns, slot_sel,
                    input ready);
    modport sink (input valid, func, item_id, frame_index, hovered, frame_ns, slot_sel,
                  output ready);
endinterface

interface lsc_rsp_if import lsc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               hit;
    logic [SLOT_W-1:0]  slot_num;
    logic [HOVER_W-1:0] hover_time_ns;
    logic               last;

    modport source (output valid, kind, hit, slot_num, hover_time_ns, last,
                    input ready);
    modport sink (input valid, kind, hit, slot_num, hover_time_ns, last,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/lsc_ctrl.sv
// Sequencing state machine for the LRU slot cache: accepts a request,
// steps the datapath through scan, commit, mark stale, flush, drain and acknowledge.
// Depends on lsc_pkg.
`default_nettype none

module lsc_ctrl import lsc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire lsc_sts_t sts,
    output lsc_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DECODE     = 3'd1;
    localparam logic [2:0] S_SCAN       = 3'd2;
    localparam logic [2:0] S_COMMIT     = 3'd3;
    localparam logic [2:0] S_ACK        = 3'd4;
    localparam logic [2:0] S_DRAIN      = 3'd5;
    localparam logic [2:0] S_DRAIN_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = (state_reg == S_IDLE);
        cmd.load   = req_valid && req_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.func)
                    FUNC_LOOKUP, FUNC_REMOVE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    FUNC_STALE:
                    begin
                        cmd.mark_stale = 1'b1;
                        state_next     = S_ACK;
                    end
                    FUNC_FLUSH:
                    begin
                        cmd.flush  = 1'b1;
                        state_next = S_ACK;
                    end
                    FUNC_DRAIN:
                    begin
                        cmd.drain_start = 1'b1;
                        state_next      = S_DRAIN;
                    end
                    default:
                    begin
                        state_next = S_ACK;
                    end
                endcase
            end
            S_SCAN:
            begin
                if ((sts.func == FUNC_LOOKUP) && sts.found)
                begin
                    state_next = S_COMMIT;
                end
                else if (sts.scan_done)
                begin
                    state_next = (sts.func == FUNC_LOOKUP) ? S_COMMIT : S_ACK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_lookup = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (sts.drain_end)
                begin
                    state_next = sts.emitted ? S_IDLE : S_ACK;
                end
                else if (sts.drain_hit)
                begin
                    cmd.drain_read = 1'b1;
                    state_next     = S_DRAIN_EMIT;
                end
                else
                begin
                    cmd.drain_skip = 1'b1;
                end
            end
            S_DRAIN_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_render = 1'b1;
                    state_next      = S_DRAIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lsc_datapath.sv
// Datapath of the LRU slot cache: slot memory with per-slot valid bits,
// pending/stale mark vectors, scan and drain counters, LRU tracking and
// the response output register. Depends on lsc_pkg and lsc_if.
`default_nettype none

module lsc_datapath import lsc_pkg::*;
#(
    parameter int SLOT_COUNT = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lsc_cmd_t           cmd,
    output lsc_sts_t                sts,
    input  wire logic [FUNC_W-1:0]  req_func,
    input  wire logic [ID_W-1:0]    req_item_id,
    input  wire logic [FRAME_W-1:0] req_frame_index,
    input  wire logic               req_hovered,
    input  wire logic [FNS_W-1:0]   req_frame_ns,
    input  wire logic [SEL_W-1:0]   req_slot_sel,
    lsc_rsp_if.source               rsp
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // request capture
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]    id_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               hov_reg;
    logic [FNS_W-1:0]   fns_reg;
    logic [SEL_W-1:0]   sel_reg;

    // slot storage
    lsc_entry_t            mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg,   valid_next;
    logic [SLOT_COUNT-1:0] pending_reg, pending_next;
    logic [SLOT_COUNT-1:0] stale_reg,   stale_next;

    // read port
    logic       rd_en;
    logic [IW-1:0] rd_addr;
    lsc_entry_t rd_entry_reg;
    logic       rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    lsc_entry_t eff;

    // scan
    logic [CW-1:0]      issue_cnt_reg, issue_cnt_next;
    logic               ev_valid_reg,  ev_valid_next;
    logic               found_reg,     found_next;
    logic [IW-1:0]      hit_idx_reg,   hit_idx_next;
    lsc_entry_t         hit_entry_reg, hit_entry_next;
    logic [IW-1:0]      victim_reg,    victim_next;
    logic [FRAME_W-1:0] oldest_reg,    oldest_next;
    logic [HOVER_W-1:0] victim_hover_reg, victim_hover_next;
    logic               scan_issue;

    // drain
    logic [CW-1:0] dr_cnt_reg, dr_cnt_next;
    logic          emitted_reg, emitted_next;
    logic          more_pending;

    // commit write
    logic       wr_en;
    logic [IW-1:0] wr_idx;
    lsc_entry_t wr_entry;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg,  out_kind_next;
    logic               out_hit_reg,   out_hit_next;
    logic [SLOT_W-1:0]  out_slot_reg,  out_slot_next;
    logic [HOVER_W-1:0] out_hover_reg, out_hover_next;
    logic               out_last_reg,  out_last_next;
    logic               out_free;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign scan_issue = cmd.scan_step && (issue_cnt_reg != CW'(SLOT_COUNT));
    assign rd_en      = scan_issue || cmd.drain_read;
    assign rd_addr    = cmd.drain_read ? dr_cnt_reg[IW-1:0] : issue_cnt_reg[IW-1:0];
    assign eff        = rd_vld_reg ? rd_entry_reg : '0;
    assign wr_en      = cmd.commit_lookup;
    assign wr_idx     = found_reg ? hit_idx_reg : victim_reg;

    always_comb
    begin
        if (found_reg)
        begin
            wr_entry.item     = hit_entry_reg.item;
            wr_entry.last_use = frame_reg;
            wr_entry.hover    = hov_reg ? (hit_entry_reg.hover + HOVER_W'(fns_reg))
                                        : hit_entry_reg.hover;
        end
        else
        begin
            wr_entry.item     = id_reg;
            wr_entry.last_use = frame_reg;
            wr_entry.hover    = victim_hover_reg;
        end
    end

    always_comb
    begin
        more_pending = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pending_reg[i] && (IW'(i) > rd_idx_reg))
            begin
                more_pending = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next        = valid_reg;
        pending_next      = pending_reg;
        stale_next        = stale_reg;
        issue_cnt_next    = issue_cnt_reg;
        ev_valid_next     = scan_issue;
        found_next        = found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_entry_next    = hit_entry_reg;
        victim_next       = victim_reg;
        oldest_next       = oldest_reg;
        victim_hover_next = victim_hover_reg;
        dr_cnt_next       = dr_cnt_reg;
        emitted_next      = emitted_reg;

        if (cmd.scan_start)
        begin
            issue_cnt_next = '0;
            found_next     = 1'b0;
        end
        if (scan_issue)
        begin
            issue_cnt_next = issue_cnt_reg + CW'(1);
        end

        // evaluate the slot read in the previous cycle
        if (ev_valid_reg && !found_reg)
        begin
            if (func_reg == FUNC_LOOKUP)
            begin
                if ((eff.item == id_reg) && !pending_reg[rd_idx_reg])
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_entry_next = eff;
                end
                else if ((rd_idx_reg == '0) || (eff.last_use < oldest_reg))
                begin
                    oldest_next       = eff.last_use;
                    victim_next       = rd_idx_reg;
                    victim_hover_next = eff.hover;
                end
            end
            else if ((id_reg != '0) && (eff.item == id_reg))
            begin
                valid_next[rd_idx_reg]   = 1'b0;
                pending_next[rd_idx_reg] = 1'b0;
                stale_next[rd_idx_reg]   = 1'b0;
            end
        end

        if (cmd.commit_lookup)
        begin
            valid_next[wr_idx]   = 1'b1;
            stale_next[wr_idx]   = 1'b0;
            pending_next[wr_idx] = found_reg ? (stale_reg[wr_idx] || hov_reg) : 1'b1;
        end

        if (cmd.mark_stale && (32'(sel_reg) < SLOT_COUNT))
        begin
            stale_next[sel_reg[IW-1:0]] = 1'b1;
        end

        if (cmd.flush)
        begin
            valid_next   = '0;
            pending_next = '0;
            stale_next   = '0;
        end

        if (cmd.drain_start)
        begin
            dr_cnt_next  = '0;
            emitted_next = 1'b0;
        end
        if (cmd.drain_skip)
        begin
            dr_cnt_next = dr_cnt_reg + CW'(1);
        end
        if (cmd.emit_render)
        begin
            pending_next[rd_idx_reg] = 1'b0;
            dr_cnt_next              = dr_cnt_reg + CW'(1);
            emitted_next             = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_hover_next = out_hover_reg;
        out_last_next  = out_last_reg;
        if (cmd.commit_lookup)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_LOOKUP;
            out_hit_next   = found_reg;
            out_slot_next  = SLOT_W'(wr_idx);
            out_hover_next = '0;
            out_last_next  = 1'b1;
        end
        else if (cmd.emit_render)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_RENDER;
            out_hit_next   = 1'b0;
            out_slot_next  = SLOT_W'(rd_idx_reg);
            out_hover_next = eff.hover;
            out_last_next  = !more_pending;
        end
        else if (cmd.emit_ack)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_ACK;
            out_hit_next   = 1'b0;
            out_slot_next  = '0;
            out_hover_next = '0;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pending_reg   <= '0;
            stale_reg     <= '0;
            issue_cnt_reg <= '0;
            ev_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            dr_cnt_reg    <= '0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            pending_reg   <= pending_next;
            stale_reg     <= stale_next;
            issue_cnt_reg <= issue_cnt_next;
            ev_valid_reg  <= ev_valid_next;
            found_reg     <= found_next;
            dr_cnt_reg    <= dr_cnt_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= req_func;
            id_reg    <= req_item_id;
            frame_reg <= req_frame_index;
            hov_reg   <= req_hovered;
            fns_reg   <= req_frame_ns;
            sel_reg   <= req_slot_sel;
        end
        if (rd_en)
        begin
            rd_vld_reg <= valid_reg[rd_addr];
            rd_idx_reg <= rd_addr;
        end
        hit_idx_reg      <= hit_idx_next;
        hit_entry_reg    <= hit_entry_next;
        victim_reg       <= victim_next;
        oldest_reg       <= oldest_next;
        victim_hover_reg <= victim_hover_next;
        out_kind_reg     <= out_kind_next;
        out_hit_reg      <= out_hit_next;
        out_slot_reg     <= out_slot_next;
        out_hover_reg    <= out_hover_next;
        out_last_reg     <= out_last_next;
    end

    assign sts.func      = func_reg;
    assign sts.found     = found_reg;
    assign sts.scan_done = (issue_cnt_reg == CW'(SLOT_COUNT)) && !ev_valid_reg;
    assign sts.out_free  = out_free;
    assign sts.drain_end = (dr_cnt_reg == CW'(SLOT_COUNT));
    assign sts.drain_hit = !sts.drain_end && pending_reg[dr_cnt_reg[IW-1:0]];
    assign sts.emitted   = emitted_reg;

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.slot_num      = out_slot_reg;
    assign rsp.hover_time_ns = out_hover_reg;
    assign rsp.last          = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/lru_slot_cache_with_pending_marks.sv
// Top level of the LRU slot cache with pending render marks.
// Instantiates lsc_ctrl and lsc_datapath; depends on lsc_pkg and lsc_if.
//
//  channel | dir | payload                                                 | per item
//  req     | in  | func, item_id, frame_index, hovered, frame_ns, slot_sel | 1
//  rsp     | out | kind, hit, slot_num, hover_time_ns, last                | 1..N
//
// Lookup and remove scan one slot per cycle through the single memory read port;
// a lookup stops early on a hit. Drain steps through every slot, reading and emitting
// a render for each pending one, and acknowledges if none is pending. Mark stale,
// flush and unused codes go straight to the acknowledge; reset clears the valid bits at once.
// A new request is taken once the previous one has handed its last transfer to the
// output register and the block is back in idle; a stalled rsp holds the block at its next emit.
`default_nettype none

module lru_slot_cache_with_pending_marks import lsc_pkg::*;
#(
    parameter int SLOT_COUNT = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    lsc_req_if.sink   req,
    lsc_rsp_if.source rsp
);

    lsc_cmd_t cmd;
    lsc_sts_t sts;

    lsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lsc_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_func        (req.func),
        .req_item_id     (req.item_id),
        .req_frame_index (req.frame_index),
        .req_hovered     (req.hovered),
        .req_frame_ns    (req.frame_ns),
        .req_slot_sel    (req.slot_sel),
        .rsp             (rsp)
    );

endmodule

`default_nettype wire

### hw/rtl/lsc_checker.sv
// Port-level checker for the LRU slot cache, bound to the top level.
// Depends on lsc_pkg.
`default_nettype none

module lsc_checker import lsc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [KIND_W-1:0]  rsp_kind,
    input wire logic               rsp_hit,
    input wire logic [SLOT_W-1:0]  rsp_slot_num,
    input wire logic [HOVER_W-1:0] rsp_hover_time_ns,
    input wire logic               rsp_last
);

    // stalled transfer holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_hit)
            && $stable(rsp_slot_num) && $stable(rsp_hover_time_ns) && $stable(rsp_last))
        else $error("rsp changed while stalled");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted twice in a row");

    a_lookup_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_LOOKUP) |-> rsp_last && (rsp_hover_time_ns == '0))
        else $error("bad lookup answer");

    a_ack_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_ACK) |-> rsp_last && !rsp_hit
            && (rsp_slot_num == '0) && (rsp_hover_time_ns == '0))
        else $error("bad acknowledge");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_kind == KIND_LOOKUP) || ((rsp_kind == KIND_RENDER) && !rsp_hit)
            || (rsp_kind == KIND_ACK))
        else $error("bad response kind");

endmodule

bind lru_slot_cache_with_pending_marks lsc_checker u_lsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_kind          (rsp.kind),
    .rsp_hit           (rsp.hit),
    .rsp_slot_num      (rsp.slot_num),
    .rsp_hover_time_ns (rsp.hover_time_ns),
    .rsp_last          (rsp.last)
);

`default_nettype wire
